[rtl/rv32d_pkg.sv]
// Shared types, opcode constants and funct3 lookup tables for the RV32I decoder.
// No dependencies; imported by rv32d_decode, rv32i_instruction_decoder and the testbench.
`timescale 1ns / 1ps

package rv32d_pkg;

	localparam int INSTR_W = 32;
	localparam int OP_W    = 6;
	localparam int FMT_W   = 3;
	localparam int REG_W   = 5;
	localparam int IMM_W   = 21;

	// Major opcodes, bits 6..0
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

	// funct3 codes that need a special look
	localparam logic [2:0] F3_ZERO = 3'b000;
	localparam logic [2:0] F3_ADD  = 3'b000;
	localparam logic [2:0] F3_SR   = 3'b101;

	typedef enum logic [FMT_W-1:0] {
		FMT_R = 3'd0,
		FMT_I = 3'd1,
		FMT_S = 3'd2,
		FMT_U = 3'd3,
		FMT_B = 3'd4,
		FMT_J = 3'd5
	} fmt_t;

	typedef enum logic [OP_W-1:0] {
		OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
		OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
		OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
		OP_SB, OP_SH, OP_SW,
		OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
		OP_SLLI, OP_SRLI, OP_SRAI,
		OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR,
		OP_SRL, OP_SRA, OP_OR, OP_AND,
		OP_ECALL, OP_EBREAK
	} op_t;

	// funct3 -> operation tables; the *_OK masks flag the funct3 codes in use
	localparam op_t BRANCH_OPS [8] = '{OP_BEQ, OP_BNE, OP_LUI, OP_LUI,
		OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
	localparam logic [7:0] BRANCH_OK = 8'b1111_0011;

	localparam op_t LOAD_OPS [8] = '{OP_LB, OP_LH, OP_LW, OP_LUI,
		OP_LBU, OP_LHU, OP_LUI, OP_LUI};
	localparam logic [7:0] LOAD_OK = 8'b0011_0111;

	localparam op_t STORE_OPS [8] = '{OP_SB, OP_SH, OP_SW, OP_LUI,
		OP_LUI, OP_LUI, OP_LUI, OP_LUI};
	localparam logic [7:0] STORE_OK = 8'b0000_0111;

	localparam op_t OPIMM_OPS [8] = '{OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU,
		OP_XORI, OP_SRLI, OP_ORI, OP_ANDI};

	localparam op_t REG_OPS [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
		OP_XOR, OP_SRL, OP_OR, OP_AND};

	// One decoded word
	typedef struct packed {
		op_t              operation;
		fmt_t             format;
		logic             illegal;
		logic [REG_W-1:0] dest_reg;
		logic [REG_W-1:0] src1_reg;
		logic [REG_W-1:0] src2_reg;
		logic [IMM_W-1:0] immediate;
	} dec_t;

endpackage

[rtl/rv32d_decode.sv]
// Combinational RV32I decode of one instruction word into a dec_t.
// Depends on rv32d_pkg.
`timescale 1ns / 1ps

module rv32d_decode
	import rv32d_pkg::*;
(
	input  logic [INSTR_W-1:0] instr,
	output dec_t               dec
);

	logic [6:0]       opc;
	logic [2:0]       f3;
	logic             b30;
	logic             known;
	logic             op_ok;
	op_t              op;
	fmt_t             fmt;
	logic [REG_W-1:0] rd;
	logic [REG_W-1:0] rs1;
	logic [REG_W-1:0] rs2;
	logic [IMM_W-1:0] imm;

	assign opc = instr[6:0];
	assign f3  = instr[14:12];
	assign b30 = instr[30];

	// Opcode and funct3 to operation and format
	always_comb begin
		known = 1'b1;
		op_ok = 1'b1;
		op    = OP_LUI;
		fmt   = FMT_R;
		case (opc)
			OPC_LUI: begin
				fmt = FMT_U;
				op  = OP_LUI;
			end
			OPC_AUIPC: begin
				fmt = FMT_U;
				op  = OP_AUIPC;
			end
			OPC_JAL: begin
				fmt = FMT_J;
				op  = OP_JAL;
			end
			OPC_JALR: begin
				fmt   = FMT_I;
				op    = OP_JALR;
				op_ok = (f3 == F3_ZERO);
			end
			OPC_BRANCH: begin
				fmt   = FMT_B;
				op    = BRANCH_OPS[f3];
				op_ok = BRANCH_OK[f3];
			end
			OPC_LOAD: begin
				fmt   = FMT_I;
				op    = LOAD_OPS[f3];
				op_ok = LOAD_OK[f3];
			end
			OPC_STORE: begin
				fmt   = FMT_S;
				op    = STORE_OPS[f3];
				op_ok = STORE_OK[f3];
			end
			OPC_OP_IMM: begin
				fmt = FMT_I;
				op  = OPIMM_OPS[f3];
				if (f3 == F3_SR && b30) begin
					op = OP_SRAI;
				end
			end
			OPC_OP: begin
				fmt = FMT_R;
				op  = REG_OPS[f3];
				if (b30 && f3 == F3_ADD) begin
					op = OP_SUB;
				end
				if (b30 && f3 == F3_SR) begin
					op = OP_SRA;
				end
			end
			OPC_SYSTEM: begin
				fmt   = FMT_I;
				op_ok = (f3 == F3_ZERO);
				op    = (instr[31:20] == 12'd0) ? OP_ECALL : OP_EBREAK;
			end
			default: begin
				known = 1'b0;
				op_ok = 1'b0;
			end
		endcase
	end

	// Register fields and immediate of the chosen format
	always_comb begin
		rd  = instr[11:7];
		rs1 = instr[19:15];
		rs2 = instr[24:20];
		imm = '0;
		case (fmt)
			FMT_I: begin
				imm = {9'd0, instr[31:20]};
				rs2 = '0;
			end
			FMT_S: begin
				imm = {9'd0, instr[31:25], instr[11:7]};
				rd  = '0;
			end
			FMT_B: begin
				imm = {8'd0, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
				rd  = '0;
			end
			FMT_U: begin
				imm = {1'b0, instr[31:12]};
				rs1 = '0;
				rs2 = '0;
			end
			FMT_J: begin
				imm = {instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
				rs1 = '0;
				rs2 = '0;
			end
			default: begin
				imm = '0;
			end
		endcase
		if (!known) begin
			rd  = '0;
			rs1 = '0;
			rs2 = '0;
		end
	end

	// Unknown operations report as illegal with operation zero
	always_comb begin
		dec.operation = op_ok ? op : OP_LUI;
		dec.format    = fmt;
		dec.illegal   = !op_ok;
		dec.dest_reg  = rd;
		dec.src1_reg  = rs1;
		dec.src2_reg  = rs2;
		dec.immediate = imm;
	end

endmodule

[rtl/rv32i_instruction_decoder.sv]
// Top level of the RV32I decoder: input register, decode logic, result register.
// Depends on rv32d_pkg and rv32d_decode.
//
//   channel | signals                                      | dir
//   --------+----------------------------------------------+-----
//   in      | in_valid, in_stall, instruction_word         | in
//   out     | out_valid, out_stall, operation, format,     | out
//           | illegal, dest_reg, src1_reg, src2_reg,       |
//           | immediate                                    |
//
// One word is taken every cycle while in_stall is low; a word reaches the output
// as it moves from the input register to the result register.
// arst_n clears both valid flags; payload registers are not reset.
// out_stall holds the result register; the input register keeps loading while
// the result register is empty, so in_stall rises only when both stages are full.
`timescale 1ns / 1ps

module rv32i_instruction_decoder
	import rv32d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [INSTR_W-1:0] instruction_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [OP_W-1:0]    operation,
	output logic [FMT_W-1:0]   format,
	output logic               illegal,
	output logic [REG_W-1:0]   dest_reg,
	output logic [REG_W-1:0]   src1_reg,
	output logic [REG_W-1:0]   src2_reg,
	output logic [IMM_W-1:0]   immediate
);

	logic               valid_s1;
	logic [INSTR_W-1:0] instr_s1;
	logic               valid_s2;
	dec_t               dec_s2;
	dec_t               dec_comb;
	logic               adv_s2;
	logic               adv_s1;

	// Stage movement
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			instr_s1 <= instruction_word;
		end
	end

	rv32d_decode u_decode (
		.instr (instr_s1),
		.dec   (dec_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			dec_s2 <= dec_comb;
		end
	end

	assign out_valid = valid_s2;
	assign operation = dec_s2.operation;
	assign format    = dec_s2.format;
	assign illegal   = dec_s2.illegal;
	assign dest_reg  = dec_s2.dest_reg;
	assign src1_reg  = dec_s2.src1_reg;
	assign src2_reg  = dec_s2.src2_reg;
	assign immediate = dec_s2.immediate;

`ifndef NO_ASSERTIONS
	// Back-pressure only when both stages hold a word and the sink is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("in_stall raised with a free stage");

	// Illegal words carry operation zero
	a_illegal_op: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && illegal) |-> (operation == OP_LUI))
		else $error("illegal word with non-zero operation");

	// U format has no source registers
	a_u_regs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && format == FMT_U) |-> (src1_reg == '0 && src2_reg == '0))
		else $error("U format with source register set");

	// S and B formats have no destination
	a_sb_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (format == FMT_S || format == FMT_B)) |-> (dest_reg == '0))
		else $error("S or B format with destination set");

	// R format carries no immediate
	a_r_imm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && format == FMT_R) |-> (immediate == '0))
		else $error("R format with non-zero immediate");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for rv32i_instruction_decoder: directed and random RV32I words.
// Depends on rv32d_pkg for opcodes, enums and the dec_t struct, and on the RTL top level.
`timescale 1ns / 1ps

module tb;
	import rv32d_pkg::*;

	// funct3 codes not given by the package
	localparam logic [2:0] F3_SLL     = 3'd1;
	localparam logic [2:0] F3_SLT     = 3'd2;
	localparam logic [2:0] F3_SLTU    = 3'd3;
	localparam logic [2:0] F3_XOR     = 3'd4;
	localparam logic [2:0] F3_OR      = 3'd6;
	localparam logic [2:0] F3_AND     = 3'd7;
	localparam logic [2:0] F3_BEQ     = 3'd0;
	localparam logic [2:0] F3_BNE     = 3'd1;
	localparam logic [2:0] F3_BR_RSVD = 3'd2;
	localparam logic [2:0] F3_BLT     = 3'd4;
	localparam logic [2:0] F3_BGE     = 3'd5;
	localparam logic [2:0] F3_BLTU    = 3'd6;
	localparam logic [2:0] F3_BGEU    = 3'd7;
	localparam logic [2:0] F3_BYTE    = 3'd0;
	localparam logic [2:0] F3_HALF    = 3'd1;
	localparam logic [2:0] F3_WORD    = 3'd2;
	localparam logic [2:0] F3_DWORD   = 3'd3;
	localparam logic [2:0] F3_BYTE_U  = 3'd4;
	localparam logic [2:0] F3_HALF_U  = 3'd5;
	localparam logic [2:0] F3_WORD_U  = 3'd6;
	localparam logic [2:0] F3_CSRRW   = 3'd1;

	localparam logic [6:0] KNOWN_OPC [10] = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR,
		OPC_BRANCH, OPC_LOAD, OPC_STORE, OPC_OP_IMM, OPC_OP, OPC_SYSTEM};
	localparam int NUM_OPS     = int'(OP_EBREAK) + 1;
	localparam int HOLD_CYCLES = 60;
	localparam int MAX_PRINTS  = 50;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [INSTR_W-1:0] instruction_word = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [OP_W-1:0]    operation;
	logic [FMT_W-1:0]   format;
	logic               illegal;
	logic [REG_W-1:0]   dest_reg;
	logic [REG_W-1:0]   src1_reg;
	logic [REG_W-1:0]   src2_reg;
	logic [IMM_W-1:0]   immediate;

	logic [INSTR_W-1:0] pending_words [$];
	dec_t               expected_decodes [$];
	int                 send_idle_pct = 16;
	int                 recv_stall_pct = 74;
	logic               hold_go = 1'b0;
	logic               hold_taken;
	int                 hold_left;
	int                 error_count = 0;
	int                 words_sent = 0;
	int                 words_checked = 0;
	int                 illegal_seen = 0;
	int                 stall_cycles = 0;
	logic [NUM_OPS-1:0] ops_seen = '0;

	rv32i_instruction_decoder dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.instruction_word (instruction_word),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.operation        (operation),
		.format           (format),
		.illegal          (illegal),
		.dest_reg         (dest_reg),
		.src1_reg         (src1_reg),
		.src2_reg         (src2_reg),
		.immediate        (immediate)
	);

	always #4 clk = ~clk;

	// Expected decode of one instruction word
	function automatic dec_t decode_rv32i(input logic [INSTR_W-1:0] w);
		dec_t       d;
		logic [2:0] f3;
		logic       known;
		logic       bad_f3;
		d = '0;
		f3 = w[14:12];
		known = 1'b1;
		bad_f3 = 1'b0;
		d.dest_reg = w[11:7];
		d.src1_reg = w[19:15];
		d.src2_reg = w[24:20];
		case (w[6:0])
		OPC_LUI: begin
			d.format = FMT_U;
			d.operation = OP_LUI;
		end
		OPC_AUIPC: begin
			d.format = FMT_U;
			d.operation = OP_AUIPC;
		end
		OPC_JAL: begin
			d.format = FMT_J;
			d.operation = OP_JAL;
		end
		OPC_JALR: begin
			d.format = FMT_I;
			if (f3 == F3_ZERO)
				d.operation = OP_JALR;
			else
				bad_f3 = 1'b1;
		end
		OPC_BRANCH: begin
			d.format = FMT_B;
			case (f3)
			F3_BEQ:  d.operation = OP_BEQ;
			F3_BNE:  d.operation = OP_BNE;
			F3_BLT:  d.operation = OP_BLT;
			F3_BGE:  d.operation = OP_BGE;
			F3_BLTU: d.operation = OP_BLTU;
			F3_BGEU: d.operation = OP_BGEU;
			default: bad_f3 = 1'b1;
			endcase
		end
		OPC_LOAD: begin
			d.format = FMT_I;
			case (f3)
			F3_BYTE:   d.operation = OP_LB;
			F3_HALF:   d.operation = OP_LH;
			F3_WORD:   d.operation = OP_LW;
			F3_BYTE_U: d.operation = OP_LBU;
			F3_HALF_U: d.operation = OP_LHU;
			default:   bad_f3 = 1'b1;
			endcase
		end
		OPC_STORE: begin
			d.format = FMT_S;
			case (f3)
			F3_BYTE: d.operation = OP_SB;
			F3_HALF: d.operation = OP_SH;
			F3_WORD: d.operation = OP_SW;
			default: bad_f3 = 1'b1;
			endcase
		end
		OPC_OP_IMM: begin
			d.format = FMT_I;
			case (f3)
			F3_ADD:  d.operation = OP_ADDI;
			F3_SLL:  d.operation = OP_SLLI;
			F3_SLT:  d.operation = OP_SLTI;
			F3_SLTU: d.operation = OP_SLTIU;
			F3_XOR:  d.operation = OP_XORI;
			F3_SR: begin
				if (w[30])
					d.operation = OP_SRAI;
				else
					d.operation = OP_SRLI;
			end
			F3_OR:   d.operation = OP_ORI;
			default: d.operation = OP_ANDI;
			endcase
		end
		OPC_OP: begin
			d.format = FMT_R;
			case (f3)
			F3_ADD: begin
				if (w[30])
					d.operation = OP_SUB;
				else
					d.operation = OP_ADD;
			end
			F3_SLL:  d.operation = OP_SLL;
			F3_SLT:  d.operation = OP_SLT;
			F3_SLTU: d.operation = OP_SLTU;
			F3_XOR:  d.operation = OP_XOR;
			F3_SR: begin
				if (w[30])
					d.operation = OP_SRA;
				else
					d.operation = OP_SRL;
			end
			F3_OR:   d.operation = OP_OR;
			default: d.operation = OP_AND;
			endcase
		end
		OPC_SYSTEM: begin
			d.format = FMT_I;
			if (f3 != F3_ZERO)
				bad_f3 = 1'b1;
			else if (w[31:20] == '0)
				d.operation = OP_ECALL;
			else
				d.operation = OP_EBREAK;
		end
		default: known = 1'b0;
		endcase

		// unknown opcode: only the flag survives
		if (!known) begin
			d = '0;
			d.illegal = 1'b1;
			return d;
		end

		// immediate and unused register fields by format
		case (d.format)
		FMT_I: begin
			d.immediate = {9'b0, w[31:20]};
			d.src2_reg = '0;
		end
		FMT_S: begin
			d.immediate = {9'b0, w[31:25], w[11:7]};
			d.dest_reg = '0;
		end
		FMT_B: begin
			d.immediate = {8'b0, w[31], w[7], w[30:25], w[11:8], 1'b0};
			d.dest_reg = '0;
		end
		FMT_U: begin
			d.immediate = {1'b0, w[31:12]};
			d.src1_reg = '0;
			d.src2_reg = '0;
		end
		FMT_J: begin
			d.immediate = {w[31], w[19:12], w[20], w[30:21], 1'b0};
			d.src1_reg = '0;
			d.src2_reg = '0;
		end
		default: d.immediate = '0;
		endcase

		if (bad_f3) begin
			d.illegal = 1'b1;
			d.operation = OP_LUI;
		end
		return d;
	endfunction

	function automatic logic [INSTR_W-1:0] pack_fields(input logic [6:0] f7,
		input logic [4:0] rs2, input logic [4:0] rs1, input logic [2:0] f3,
		input logic [4:0] rd, input logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	// Mostly known opcodes with random bits above; some raw noise
	function automatic logic [INSTR_W-1:0] random_word();
		logic [INSTR_W-1:0] w;
		w = $urandom();
		if ($urandom_range(99) >= 15) begin
			w[6:0] = KNOWN_OPC[$urandom_range(9)];
			if ((w[6:0] == OPC_SYSTEM || w[6:0] == OPC_JALR) && $urandom_range(1) == 0)
				w[14:12] = F3_ZERO;
			// ECALL needs the whole upper field clear
			if (w[6:0] == OPC_SYSTEM && $urandom_range(3) == 0)
				w[31:20] = '0;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	// Driver: offers pending words, holds them while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			instruction_word <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_decodes.push_back(decode_rv32i(instruction_word));
				words_sent++;
			end else if (in_valid) begin
				stall_cycles++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					instruction_word <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_go && !hold_taken) begin
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each decoded word against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		dec_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_decodes.size() == 0) begin
					report_mismatch("word with no decode waiting", '0, {26'b0, operation});
				end else begin
					want = expected_decodes.pop_front();
					words_checked++;
					if (operation !== want.operation)
						report_mismatch("operation", 32'(want.operation), 32'(operation));
					if (format !== want.format)
						report_mismatch("format", 32'(want.format), 32'(format));
					if (illegal !== want.illegal)
						report_mismatch("illegal", 32'(want.illegal), 32'(illegal));
					if (dest_reg !== want.dest_reg)
						report_mismatch("dest_reg", 32'(want.dest_reg), 32'(dest_reg));
					if (src1_reg !== want.src1_reg)
						report_mismatch("src1_reg", 32'(want.src1_reg), 32'(src1_reg));
					if (src2_reg !== want.src2_reg)
						report_mismatch("src2_reg", 32'(want.src2_reg), 32'(src2_reg));
					if (immediate !== want.immediate)
						report_mismatch("immediate", 32'(want.immediate), 32'(immediate));
					if (want.illegal)
						illegal_seen++;
					else
						ops_seen[want.operation] = 1'b1;
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Stimulus and run control
	initial begin : stimulus
		int i;

		// field extremes and special cases
		pending_words.push_back(32'h0000_0000);
		pending_words.push_back(32'hFFFF_FFFF);
		pending_words.push_back({20'hFFFFF, 5'd31, OPC_LUI});
		pending_words.push_back({20'h00000, 5'd0, OPC_LUI});
		pending_words.push_back({20'hFFFFF, 5'd31, OPC_AUIPC});
		pending_words.push_back({20'hFFFFF, 5'd31, OPC_JAL});
		pending_words.push_back({20'h00000, 5'd0, OPC_JAL});
		pending_words.push_back(pack_fields(7'h7F, 5'd31, 5'd31, F3_ZERO, 5'd31, OPC_JALR));
		pending_words.push_back(pack_fields(7'h00, 5'd0, 5'd5, F3_SLL, 5'd1, OPC_JALR));
		pending_words.push_back(pack_fields(7'h7F, 5'd31, 5'd31, F3_BGEU, 5'd31, OPC_BRANCH));
		pending_words.push_back(pack_fields(7'h2A, 5'd3, 5'd4, F3_BR_RSVD, 5'd9, OPC_BRANCH));
		pending_words.push_back(pack_fields(7'h11, 5'd7, 5'd8, F3_DWORD, 5'd2, OPC_LOAD));
		pending_words.push_back(pack_fields(7'h40, 5'd1, 5'd2, F3_WORD_U, 5'd3, OPC_LOAD));
		pending_words.push_back(pack_fields(7'h7F, 5'd31, 5'd31, F3_WORD, 5'd31, OPC_STORE));
		pending_words.push_back(pack_fields(7'h05, 5'd6, 5'd7, F3_DWORD, 5'd8, OPC_STORE));
		pending_words.push_back(32'hFFFF_FF93);
		pending_words.push_back(pack_fields(7'h20, 5'd7, 5'd2, F3_SR, 5'd3, OPC_OP_IMM));
		pending_words.push_back(pack_fields(7'h00, 5'd7, 5'd2, F3_SR, 5'd3, OPC_OP_IMM));
		pending_words.push_back(pack_fields(7'h20, 5'd4, 5'd5, F3_SLL, 5'd6, OPC_OP_IMM));
		pending_words.push_back(pack_fields(7'h20, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP));
		pending_words.push_back(pack_fields(7'h00, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP));
		pending_words.push_back(pack_fields(7'h20, 5'd31, 5'd0, F3_SR, 5'd31, OPC_OP));
		pending_words.push_back(pack_fields(7'h7F, 5'd9, 5'd10, F3_OR, 5'd11, OPC_OP));
		pending_words.push_back({12'h000, 5'd0, F3_ZERO, 5'd0, OPC_SYSTEM});
		pending_words.push_back({12'h001, 5'd0, F3_ZERO, 5'd0, OPC_SYSTEM});
		pending_words.push_back({12'h000, 5'd31, F3_ZERO, 5'd31, OPC_SYSTEM});
		pending_words.push_back({12'h800, 5'd1, F3_ZERO, 5'd2, OPC_SYSTEM});
		pending_words.push_back({12'h300, 5'd1, F3_CSRRW, 5'd2, OPC_SYSTEM});
		for (i = 0; i < 360; i++)
			pending_words.push_back(random_word());

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender now idles often, receiver rarely
		while (pending_words.size() != 0)
			@(negedge clk);
		send_idle_pct = 74;
		recv_stall_pct = 16;
		for (i = 0; i < 380; i++)
			pending_words.push_back(random_word());

		// no idling, opened by a long hold-off at the output
		while (pending_words.size() != 0)
			@(negedge clk);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_go = 1'b1;
		for (i = 0; i < 385; i++)
			pending_words.push_back(random_word());

		while (pending_words.size() != 0 || in_valid || expected_decodes.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("%0d words sent, %0d decodes checked, %0d flagged illegal, %0d of %0d operations",
			words_sent, words_checked, illegal_seen, $countones(ops_seen), NUM_OPS);
		$display("input held off for %0d cycles; %0d mismatches", stall_cycles, error_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
